// ===== hdl/tdif_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// T10 DIF package
// Shared types, register indexes, status codes and the CRC-16 byte update.
// ---------------------------------------------------------------------------
package tdif_pkg;

   typedef struct packed {
      logic [7:0] data_in;
      logic       start_run;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       block_end;
      logic [2:0] block_status;
   } rsp_type;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 32;

   localparam logic [CsrIndexWidth-1:0] REG_MODE      = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_BLOCK     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_META      = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_FLAGS     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_START_REF = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_APP_TAG   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] REG_APP_MASK  = 3'd6;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_GUARD     = 3'd1;
   localparam logic [2:0] STATUS_APP       = 3'd2;
   localparam logic [2:0] STATUS_REF       = 3'd3;
   localparam logic [2:0] STATUS_UNCHECKED = 3'd4;

   localparam logic [15:0] ESCAPE_APP_TAG = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'h8BB7;

   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = 2;

   // Configuration snapshot handed from the register file to the front part.
   typedef struct packed {
      logic        mode;
      logic [15:0] data_len;
      logic [7:0]  meta_len;
      logic [2:0]  check_flags;
      logic [31:0] start_ref_tag;
      logic [15:0] app_tag;
      logic [15:0] app_tag_mask;
   } cfg_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== hdl/tdif_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// T10 DIF front part
// Tracks the block position, runs the guard CRC, captures the stored DIF
// and computes each byte's result, which goes into the result queue.
// ---------------------------------------------------------------------------
module tdif_front (
   input  logic              clock,
   input  logic              reset,
   input  tdif_pkg::cfg_type cfg,
   input  logic              take,
   input  tdif_pkg::req_type req_word,
   output tdif_pkg::rsp_type rsp_word
);
   import tdif_pkg::*;

   logic [16:0] pos_ff, pos_in, pos_cur;
   logic [15:0] crc_ff, crc_in, crc_cur;
   logic [31:0] rtag_ff, rtag_in, rtag_cur;
   logic [15:0] sguard_ff, sguard_in, sguard_cur;
   logic [15:0] sapp_ff, sapp_in, sapp_cur;
   logic [31:0] sref_ff, sref_in, sref_cur;
   logic        fail_ff, fail_in, fail_cur;
   logic [16:0] k;
   logic [17:0] total;
   logic [7:0]  o;
   logic        bend;
   logic [2:0]  st;
   logic        gen;

   always_comb begin
      pos_cur = pos_ff; crc_cur = crc_ff; rtag_cur = rtag_ff;
      sguard_cur = sguard_ff; sapp_cur = sapp_ff; sref_cur = sref_ff;
      fail_cur = fail_ff;
      if (req_word.start_run) begin
         pos_cur = '0; crc_cur = '0; rtag_cur = cfg.start_ref_tag;
         sguard_cur = '0; sapp_cur = '0; sref_cur = '0; fail_cur = 1'b0;
      end
      pos_in = pos_cur; crc_in = crc_cur; rtag_in = rtag_cur;
      sguard_in = sguard_cur; sapp_in = sapp_cur; sref_in = sref_cur;
      fail_in = fail_cur;
      o = req_word.data_in; bend = 1'b0; st = STATUS_OK;
      gen = !cfg.mode;
      k = pos_cur - {1'b0, cfg.data_len};
      total = {2'b00, cfg.data_len} + {10'd0, cfg.meta_len};
      if (cfg.meta_len < 8'd8) begin
         pos_in = '0; crc_in = '0;
      end else begin
         if (pos_cur < {1'b0, cfg.data_len}) begin
            crc_in = crc_byte(crc_cur, req_word.data_in);
         end else if (k < 17'd2) begin
            if (k[0]) begin
               sguard_in[7:0] = req_word.data_in;
               if (gen && cfg.check_flags[0]) o = crc_cur[7:0];
            end else begin
               sguard_in[15:8] = req_word.data_in;
               if (gen && cfg.check_flags[0]) o = crc_cur[15:8];
            end
         end else if (k < 17'd4) begin
            if (k[0]) begin
               sapp_in[7:0] = req_word.data_in;
               if (gen && cfg.check_flags[1]) o = cfg.app_tag[7:0];
            end else begin
               sapp_in[15:8] = req_word.data_in;
               if (gen && cfg.check_flags[1]) o = cfg.app_tag[15:8];
            end
         end else if (k < 17'd8) begin
            case (k[1:0])
               2'd0: begin
                  sref_in[31:24] = req_word.data_in;
                  if (gen && cfg.check_flags[2]) o = rtag_cur[31:24];
               end
               2'd1: begin
                  sref_in[23:16] = req_word.data_in;
                  if (gen && cfg.check_flags[2]) o = rtag_cur[23:16];
               end
               2'd2: begin
                  sref_in[15:8] = req_word.data_in;
                  if (gen && cfg.check_flags[2]) o = rtag_cur[15:8];
               end
               default: begin
                  sref_in[7:0] = req_word.data_in;
                  if (gen && cfg.check_flags[2]) o = rtag_cur[7:0];
               end
            endcase
         end
         if ({1'b0, pos_cur} + 18'd1 >= total) begin
            bend = 1'b1;
            if (!gen) begin
               if (fail_cur) begin
                  st = STATUS_UNCHECKED;
               end else if (sapp_in != ESCAPE_APP_TAG) begin
                  if (cfg.check_flags[0] && sguard_in != crc_in)
                     st = STATUS_GUARD;
                  else if (cfg.check_flags[1] && ((sapp_in & ~cfg.app_tag_mask) != cfg.app_tag))
                     st = STATUS_APP;
                  else if (cfg.check_flags[2] && sref_in != rtag_cur)
                     st = STATUS_REF;
                  if (st != STATUS_OK) fail_in = 1'b1;
               end
            end
            rtag_in = rtag_cur + 32'd1;
            pos_in = '0; crc_in = '0;
         end else begin
            pos_in = pos_cur + 17'd1;
         end
      end
      rsp_word.data_out = o;
      rsp_word.block_end = bend;
      rsp_word.block_status = st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; crc_ff <= '0; rtag_ff <= '0; sguard_ff <= '0;
         sapp_ff <= '0; sref_ff <= '0; fail_ff <= 1'b0;
      end else if (take) begin
         pos_ff <= pos_in; crc_ff <= crc_in; rtag_ff <= rtag_in;
         sguard_ff <= sguard_in; sapp_ff <= sapp_in; sref_ff <= sref_in;
         fail_ff <= fail_in;
      end
   end

endmodule

// ===== hdl/tdif_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// T10 DIF result queue
// Small register queue between the front part and the result port.
// ---------------------------------------------------------------------------
module tdif_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tdif_pkg::rsp_type push_word,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output tdif_pkg::rsp_type head_word
);
   import tdif_pkg::*;

   rsp_type                  mem_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QueuePtrWidth:0]   cnt_ff, cnt_in;
   logic                     do_push, do_pop;

   assign full = (cnt_ff == QueueDepth[QueuePtrWidth:0]);
   assign empty = (cnt_ff == '0);
   assign head_word = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_in = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{QueuePtrWidth{1'b0}}, do_push} - {{QueuePtrWidth{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== hdl/t10_dif_generate_verify.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// T10 DIF generate and verify
// Byte-stream protection information inserter and checker.
// ---------------------------------------------------------------------------
// One byte is taken per clock whenever the result queue has room, so the
// sustained rate is one byte per cycle; a byte's result enters the queue in
// the cycle it is accepted and can be popped on the next cycle. The front
// part holds the block position, the CRC-16 T10-DIF guard (one byte per
// cycle, when taken, through an XOR network) and the captured DIF fields,
// and decides each byte's output and the block status on the last byte
// of a block. A four-word queue decouples it from the result side, so a
// stalled reader only blocks input once the queue is full. Configuration
// registers are written through the csr port and should change only while
// the block is idle; indexes beyond the register list are ignored.
module t10_dif_generate_verify (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  tdif_pkg::req_type                    req_word,
   output logic                                 full,
   output logic                                 empty,
   input  logic                                 pop,
   output tdif_pkg::rsp_type                    rsp_word,
   input  logic                                 csr_write,
   input  logic [tdif_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [tdif_pkg::CsrDataWidth-1:0]    csr_data
);
   import tdif_pkg::*;

   cfg_type cfg_ff;
   rsp_type front_word;
   logic    take;

   // Register file: one write port, fields truncated to their widths.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= 1'b0;
         cfg_ff.data_len <= 16'd512;
         cfg_ff.meta_len <= 8'd8;
         cfg_ff.check_flags <= 3'd7;
         cfg_ff.start_ref_tag <= '0;
         cfg_ff.app_tag <= '0;
         cfg_ff.app_tag_mask <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_MODE:      cfg_ff.mode <= csr_data[0];
            REG_BLOCK:     cfg_ff.data_len <= csr_data[15:0];
            REG_META:      cfg_ff.meta_len <= csr_data[7:0];
            REG_FLAGS:     cfg_ff.check_flags <= csr_data[2:0];
            REG_START_REF: cfg_ff.start_ref_tag <= csr_data;
            REG_APP_TAG:   cfg_ff.app_tag <= csr_data[15:0];
            REG_APP_MASK:  cfg_ff.app_tag_mask <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   assign take = push && !full;

   tdif_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .take     (take),
      .req_word (req_word),
      .rsp_word (front_word)
   );

   tdif_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_word (front_word),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head_word (rsp_word)
   );

endmodule
